### src/lss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lss_pkg
// Shared types and constants of the bounded stack with search.
// ----------------------------------------------------------------------------
package lss_pkg;

  localparam int DEPTH  = 64;
  localparam int DATA_W = 32;
  localparam int OP_W   = 2;
  localparam int STAT_W = 3;
  localparam int POS_W  = 7;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  typedef enum logic [OP_W-1:0] {
    OP_PUSH    = 2'd0,
    OP_POP     = 2'd1,
    OP_DISPLAY = 2'd2,
    OP_SEARCH  = 2'd3
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_PUSHED   = 3'd0,
    ST_POPPED   = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_FOUND    = 3'd3,
    ST_NOTFOUND = 3'd4,
    ST_OVERFLOW = 3'd5,
    ST_ELEMENT  = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_POP_RD,
    S_SCAN
  } state_e;

  typedef enum logic [1:0] {
    ITEM_ZERO,
    ITEM_VALUE,
    ITEM_READ
  } item_sel_e;

  typedef struct packed {
    logic [OP_W-1:0]          op;
    logic signed [DATA_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic signed [DATA_W-1:0] item;
    logic [POS_W-1:0]         position;
    logic                     last;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic      load;
    logic      push;
    logic      pop;
    logic      start_scan;
    logic      step;
    logic      emit;
    status_e   status;
    item_sel_e item_sel;
    logic      pos_en;
    logic      last;
  } lss_cmd_t;

  // datapath to controller
  typedef struct packed {
    op_e  op;
    logic empty;
    logic full;
    logic match;
    logic idx_zero;
    logic out_free;
  } lss_stat_t;

endpackage

### src/lss_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lss_ctrl
// Sequencer of the stack: decodes each operation and steps the datapath.
// ----------------------------------------------------------------------------
module lss_ctrl import lss_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  lss_stat_t stat_i,
  output lss_cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        unique case (stat_i.op)
          OP_PUSH: begin
            if (stat_i.out_free) state_d = S_IDLE;
          end
          OP_POP: begin
            if (!stat_i.empty) state_d = S_POP_RD;
            else if (stat_i.out_free) state_d = S_IDLE;
          end
          default: begin
            if (!stat_i.empty) state_d = S_SCAN;
            else if (stat_i.out_free) state_d = S_IDLE;
          end
        endcase
      end
      S_POP_RD: begin
        if (stat_i.out_free) state_d = S_IDLE;
      end
      S_SCAN: begin
        if (stat_i.op == OP_DISPLAY) begin
          if (stat_i.out_free && stat_i.idx_zero) state_d = S_IDLE;
        end else if ((stat_i.match || stat_i.idx_zero) && stat_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.status   = ST_EMPTY;
    cmd_o.item_sel = ITEM_ZERO;
    cmd_o.last     = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      S_EXEC: begin
        unique case (stat_i.op)
          OP_PUSH: begin
            cmd_o.emit = stat_i.out_free;
            if (stat_i.full) begin
              cmd_o.status = ST_OVERFLOW;
            end else begin
              cmd_o.push     = stat_i.out_free;
              cmd_o.status   = ST_PUSHED;
              cmd_o.item_sel = ITEM_VALUE;
            end
          end
          OP_POP: begin
            if (stat_i.empty) cmd_o.emit = stat_i.out_free;
            else              cmd_o.pop  = 1'b1;
          end
          default: begin
            if (stat_i.empty) begin
              cmd_o.emit   = stat_i.out_free;
              cmd_o.status = (stat_i.op == OP_SEARCH) ? ST_NOTFOUND : ST_EMPTY;
            end else begin
              cmd_o.start_scan = 1'b1;
            end
          end
        endcase
      end
      S_POP_RD: begin
        cmd_o.emit     = stat_i.out_free;
        cmd_o.status   = ST_POPPED;
        cmd_o.item_sel = ITEM_READ;
      end
      S_SCAN: begin
        if (stat_i.op == OP_DISPLAY) begin
          // one element per free output slot, top first
          cmd_o.emit     = stat_i.out_free;
          cmd_o.status   = ST_ELEMENT;
          cmd_o.item_sel = ITEM_READ;
          cmd_o.pos_en   = 1'b1;
          cmd_o.last     = stat_i.idx_zero;
          cmd_o.step     = stat_i.out_free && !stat_i.idx_zero;
        end else if (stat_i.match) begin
          cmd_o.emit     = stat_i.out_free;
          cmd_o.status   = ST_FOUND;
          cmd_o.item_sel = ITEM_VALUE;
          cmd_o.pos_en   = 1'b1;
        end else if (stat_i.idx_zero) begin
          cmd_o.emit   = stat_i.out_free;
          cmd_o.status = ST_NOTFOUND;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

### src/lss_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lss_dp
// Stack memory, fill count, scan index and the output register.
// ----------------------------------------------------------------------------
module lss_dp import lss_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_word_t  in_data_i,
  input  lss_cmd_t  cmd_i,
  output lss_stat_t stat_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_data_o
);

  logic signed [DATA_W-1:0] mem [DEPTH];

  op_e                      op_q;
  logic signed [DATA_W-1:0] value_q;
  logic [CNT_W-1:0]         count_q, count_d;
  logic [ADDR_W-1:0]        idx_q;
  logic signed [DATA_W-1:0] rd_q;
  logic                     out_valid_q, out_valid_d;
  out_word_t                out_q;

  logic [ADDR_W-1:0]        top_addr;
  logic [ADDR_W-1:0]        rd_addr;
  logic                     rd_en;
  logic [CNT_W-1:0]         pos_cnt;

  assign top_addr = ADDR_W'(count_q - CNT_W'(1));
  assign rd_en    = cmd_i.pop || cmd_i.start_scan || cmd_i.step;
  assign rd_addr  = cmd_i.step ? (idx_q - ADDR_W'(1)) : top_addr;
  assign pos_cnt  = count_q - CNT_W'(idx_q);

  always_comb begin
    count_d = count_q;
    if (cmd_i.push)     count_d = count_q + CNT_W'(1);
    else if (cmd_i.pop) count_d = count_q - CNT_W'(1);
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.emit)       out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= op_e'(in_data_i.op);
      value_q <= in_data_i.value;
    end
    if (cmd_i.start_scan) idx_q <= top_addr;
    else if (cmd_i.step)  idx_q <= idx_q - ADDR_W'(1);
    if (cmd_i.emit) begin
      out_q.status <= cmd_i.status;
      case (cmd_i.item_sel)
        ITEM_VALUE: out_q.item <= value_q;
        ITEM_READ:  out_q.item <= rd_q;
        default:    out_q.item <= '0;
      endcase
      out_q.position <= cmd_i.pos_en ? POS_W'(pos_cnt) : '0;
      out_q.last     <= cmd_i.last;
    end
  end

  // stack memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) mem[ADDR_W'(count_q)] <= value_q;
    if (rd_en)      rd_q <= mem[rd_addr];
  end

  assign stat_o.op       = op_q;
  assign stat_o.empty    = (count_q == '0);
  assign stat_o.full     = (count_q == CNT_W'(DEPTH));
  assign stat_o.match    = (rd_q == value_q);
  assign stat_o.idx_zero = (idx_q == '0);
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### src/lifo_stack_with_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lifo_stack_with_search
// Bounded LIFO stack of signed 32-bit words with pop, display and search.
// ----------------------------------------------------------------------------
// Each input word carries an operation and a value. Push stores the value, or
// answers overflow when DEPTH entries are held. Pop returns the top entry,
// or the empty status when empty. Display lists all entries top first,
// positions 1 up, with last set on the bottom one; an empty stack gives one
// empty status. Search answers with the 1-based position from the top of
// the first equal entry, or not found. Every other operation gives exactly
// one result word with last set. Steps with the output always ready: push
// goes through accept and execute; pop through accept, read and deliver;
// display and search through accept, execute and scan. The single read
// port of the stack memory sets the scan pace: one entry per cycle, walking
// from the top down. A result waits in the output register while the next
// input word is taken. A display holds its walk while that register is
// occupied; a search keeps walking and holds only once its answer is ready.
// No clearing pass is needed after reset: only entries below the fill count
// are ever read.
// ----------------------------------------------------------------------------
module lifo_stack_with_search import lss_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_data_o
);

  lss_cmd_t  cmd;
  lss_stat_t stat;

  // sequencer: decode the latched operation, drive the datapath
  lss_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // storage, fill count, scan index and output register
  lss_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

### sim/tb_lifo_stack_with_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lifo_stack_with_search
// Self-checking testbench of the bounded stack with search.
// ----------------------------------------------------------------------------
// Sends operation words into the stack over a valid/ready channel. A shadow
// copy of the stack works out every result word when its operation word is
// accepted. A checker compares each accepted result word field by field with
// the oldest expected word. Directed tests cover the answers of an empty
// stack, value extremes, duplicate search hits and overflow on a full stack.
// A random phase then swings the fill level up and down, with random sender
// gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_lifo_stack_with_search;
  import lss_pkg::*;

  localparam int RANDOM_WORDS = 90;
  localparam int DRAIN_CYCLES = DEPTH + 8;
  localparam int IDLE_LIMIT   = 1000;
  localparam int MAX_REPORTS  = 60;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_word_t  in_word   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_word;

  // when set, that side draws a random wait for every word
  logic src_gaps    = 1'b0;
  logic sink_stalls = 1'b0;

  // shadow of the stack contents; entry 0 is the bottom
  logic signed [DATA_W-1:0] stack_copy [DEPTH];
  int unsigned              stack_fill   = 0;
  out_word_t                expected_words [$];

  int          error_count   = 0;
  int          words_checked = 0;
  int unsigned sink_wait     = 0;
  int unsigned quiet_cycles  = 0;

  lifo_stack_with_search dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_word),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_word)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Work out the result words of one accepted operation and queue them.
  task automatic predict_results(input op_e op, input logic signed [DATA_W-1:0] val);
    out_word_t   w;
    int unsigned pos;
    bit          hit;
    w      = '0;
    w.last = 1'b1;
    hit    = 1'b0;
    if (op == OP_DISPLAY && stack_fill != 0) begin
      // list top first, last set on the bottom entry
      for (pos = 1; pos <= stack_fill; pos++) begin
        w.status   = ST_ELEMENT;
        w.item     = stack_copy[stack_fill - pos];
        w.position = pos[POS_W-1:0];
        w.last     = (pos == stack_fill);
        expected_words.push_back(w);
      end
    end else begin
      case (op)
        OP_PUSH: begin
          if (stack_fill == DEPTH) begin
            w.status = ST_OVERFLOW;
          end else begin
            stack_copy[stack_fill] = val;
            stack_fill++;
            w.status = ST_PUSHED;
            w.item   = val;
          end
        end
        OP_POP: begin
          if (stack_fill == 0) begin
            w.status = ST_EMPTY;
          end else begin
            stack_fill--;
            w.status = ST_POPPED;
            w.item   = stack_copy[stack_fill];
          end
        end
        OP_DISPLAY: begin
          w.status = ST_EMPTY;
        end
        default: begin
          w.status = ST_NOTFOUND;
          for (pos = 1; pos <= stack_fill; pos++) begin
            if (!hit && stack_copy[stack_fill - pos] == val) begin
              hit        = 1'b1;
              w.status   = ST_FOUND;
              w.item     = val;
              w.position = pos[POS_W-1:0];
            end
          end
        end
      endcase
      expected_words.push_back(w);
    end
  endtask

  // Present one word, hold it until accepted, then predict its results.
  // Valid stays high after acceptance so that a word with no gap follows at
  // once; the caller drops it when the stimulus ends.
  task automatic send_word(input op_e op, input logic signed [DATA_W-1:0] val);
    int unsigned gap;
    gap = src_gaps ? $urandom_range(0, 19) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= {op, val};
    do @(posedge clk); while (!in_ready);
    predict_results(op, val);
  endtask

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    error_count++;
    if (error_count <= MAX_REPORTS)
      $display("%0t: result word %0d: %s got %0h, want %0h",
               $time, words_checked, what, got, want);
  endtask

  // Mostly full-range values, some from a tiny pool to force duplicates,
  // some copied from the stack so that searches hit.
  function automatic logic signed [DATA_W-1:0] pick_value();
    int unsigned sel;
    sel = $urandom_range(0, 3);
    if (sel == 0) return DATA_W'(int'($urandom_range(0, 7)) - 4);
    if (sel == 1 && stack_fill != 0) return stack_copy[$urandom_range(0, stack_fill - 1)];
    return $urandom;
  endfunction

  // Check every accepted result word and draw the stall before the next one.
  always @(posedge clk) begin : result_check
    out_word_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        words_checked++;
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected word, item", out_word.item, '0);
        end else begin
          want = expected_words.pop_front();
          if (out_word.status !== want.status)
            report_mismatch("status", DATA_W'(out_word.status), DATA_W'(want.status));
          if (out_word.item !== want.item)
            report_mismatch("item", out_word.item, want.item);
          if (out_word.position !== want.position)
            report_mismatch("position", DATA_W'(out_word.position),
                            DATA_W'(want.position));
          if (out_word.last !== want.last)
            report_mismatch("last", DATA_W'(out_word.last), DATA_W'(want.last));
        end
        sink_wait = sink_stalls ? $urandom_range(0, 19) : 0;
        out_ready <= (sink_wait == 0);
      end else if (!out_ready) begin
        if (sink_wait > 1) sink_wait--;
        else out_ready <= 1'b1;
      end
    end
  end

  // Stop a hung run: count cycles in which neither channel moves a word.
  always @(posedge clk) begin : watchdog
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Pop, display and search on an empty stack.
  task automatic test_empty_answers();
    src_gaps    = 1'b1;
    sink_stalls = 1'b1;
    send_word(OP_POP, $urandom);
    send_word(OP_DISPLAY, $urandom);
    send_word(OP_SEARCH, $urandom);
  endtask

  // Extreme values through push, display, search and pop.
  task automatic test_value_extremes();
    src_gaps    = 1'b0;
    sink_stalls = 1'b0;
    send_word(OP_PUSH, 32'sh8000_0000);
    send_word(OP_PUSH, 32'sh7fff_ffff);
    send_word(OP_PUSH, -32'sd1);
    send_word(OP_PUSH, 32'sd0);
    send_word(OP_DISPLAY, 32'sd0);
    send_word(OP_SEARCH, 32'sh8000_0000);
    send_word(OP_SEARCH, 32'sd1);
    repeat (4) send_word(OP_POP, 32'sh7fff_ffff);
  endtask

  // Search must report the match nearest the top.
  task automatic test_duplicate_search();
    src_gaps    = 1'b1;
    sink_stalls = 1'b0;
    send_word(OP_PUSH, 32'sd7);
    send_word(OP_PUSH, -32'sd3);
    send_word(OP_PUSH, 32'sd7);
    send_word(OP_SEARCH, 32'sd7);
    send_word(OP_POP, 32'sd0);
    send_word(OP_SEARCH, 32'sd7);
    send_word(OP_POP, 32'sd0);
    send_word(OP_POP, 32'sd0);
  endtask

  // Fill to DEPTH, push past it, list and search the full stack.
  task automatic test_full_stack();
    src_gaps    = 1'b0;
    sink_stalls = 1'b1;
    while (stack_fill < DEPTH) send_word(OP_PUSH, pick_value());
    send_word(OP_PUSH, $urandom);
    send_word(OP_PUSH, $urandom);
    send_word(OP_DISPLAY, $urandom);
    send_word(OP_SEARCH, stack_copy[0]);
    send_word(OP_SEARCH, stack_copy[DEPTH-1]);
  endtask

  // Random operations in fill and drain swings; traffic shaping changes
  // every 30 words, including stretches with no idling at all.
  task automatic test_random_traffic();
    bit          grow;
    int unsigned r;
    op_e         op;
    grow = (stack_fill < DEPTH / 2);
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 30 == 0) begin
        r           = $urandom_range(0, 3);
        src_gaps    = r[0];
        sink_stalls = r[1];
      end
      if (stack_fill == DEPTH && $urandom_range(0, 3) == 0) grow = 1'b0;
      else if (stack_fill == 0 && $urandom_range(0, 2) == 0) grow = 1'b1;
      else if ($urandom_range(0, 31) == 0) grow = !grow;
      r = $urandom_range(0, 99);
      if (grow)
        op = (r < 55) ? OP_PUSH : (r < 65) ? OP_POP : (r < 75) ? OP_DISPLAY : OP_SEARCH;
      else
        op = (r < 10) ? OP_PUSH : (r < 65) ? OP_POP : (r < 75) ? OP_DISPLAY : OP_SEARCH;
      send_word(op, pick_value());
    end
  endtask

  initial begin : run
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_answers();
    test_value_extremes();
    test_duplicate_search();
    test_full_stack();
    test_random_traffic();
    in_valid <= 1'b0;
    // drain outstanding results, then leave room for any stray word
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### sim.f
src/lss_pkg.sv
src/lss_ctrl.sv
src/lss_dp.sv
src/lifo_stack_with_search.sv
sim/tb_lifo_stack_with_search.sv
